[rtl/assert_macros.svh]
// assertion macros for the cmac engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/acmac_pkg.sv]
package acmac_pkg;

  localparam int KeyBits = 128;
  localparam int Rounds = KeyBits / 32 + 6;
  localparam int BlockBits = 128;
  localparam int QueueDepth = 2;

  localparam logic [7:0] RbConst = 8'h87;
  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow = 2'd1;
  localparam logic [1:0] RegInertPad = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBKEY,
    ST_BLOCK,
    ST_OUT
  } eng_state_t;

  // classified block handed from the front to the back
  typedef struct packed {
    logic [BlockBits-1:0] data;
    logic                 last;
    logic                 padded;
  } blk_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [BlockBits-1:0] aes_round(input logic [BlockBits-1:0] s_in,
                                                     input logic [BlockBits-1:0] rk,
                                                     input logic             final_rnd);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlockBits-1:0] r;
    for (int i = 0; i < 16; i++) s[i] = sbox(s_in[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)%4)];
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r ^ rk;
  endfunction

  function automatic logic [BlockBits-1:0] next_rkey(input logic [BlockBits-1:0] k,
                                                     input logic [7:0]           rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlockBits-1:0] dbl(input logic [BlockBits-1:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RbConst : 8'h00)};
  endfunction

endpackage

[rtl/acmac_front.sv]
module acmac_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [127:0]            in_block,
  input  logic [4:0]              in_count,
  input  logic                    in_last,
  input  logic                    inert_pad,
  output logic                    q_valid,
  input  logic                    q_ready,
  output acmac_pkg::blk_item_t    q_item
);
  import acmac_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  blk_item_t           mem [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr;
  logic [PtrBits-1:0]  rd_ptr;
  logic [PtrBits:0]    fill;
  blk_item_t           cls;
  logic [4:0]          n;
  logic                push;
  logic                pop;

  // pad and classify the incoming block
  always_comb begin
    n = (in_count > 5'd16) ? 5'd16 : in_count;
    cls.last = in_last;
    cls.padded = (n < 5'd16) && !inert_pad;
    for (int j = 0; j < 16; j++) begin
      if (j < n) cls.data[127-8*j -: 8] = in_block[127-8*j -: 8];
      else if (j == n && !inert_pad) cls.data[127-8*j -: 8] = PadMark;
      else cls.data[127-8*j -: 8] = 8'h00;
    end
  end

  assign in_ready = (fill != QueueDepth[PtrBits:0]);
  assign q_valid = (fill != '0);
  assign q_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {{PtrBits{1'b0}}, push} - {{PtrBits{1'b0}}, pop};
    end
  end
endmodule

[rtl/acmac_back.sv]
module acmac_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [127:0]            key,
  input  logic                    key_wr,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  acmac_pkg::blk_item_t    q_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [127:0]            out_tag
);
  import acmac_pkg::*;

  eng_state_t      state;
  eng_state_t      state_next;
  logic [3:0]      rnd;
  logic [127:0]    st;
  logic [127:0]    rk;
  logic [127:0]    rk_next;
  logic [127:0]    chain;
  logic [127:0]    k1;
  logic [127:0]    k2;
  logic            ready_keys;
  logic            cur_last;
  logic [7:0]      rc;
  logic [127:0]    round_out;
  logic [127:0]    start_val;
  logic            done_rnd;
  logic            take;
  logic [127:0]    l_val;
  logic            out_full;
  logic [127:0]    out_reg;
  logic            can_load;
  logic            load_out;
  logic [127:0]    load_val;

  assign done_rnd = (rnd == Rounds[3:0]);
  assign take = (state == ST_IDLE) && q_valid && ready_keys;
  assign can_load = !out_full || out_ready;

  always_comb begin
    case (rnd)
      4'd1: rc = 8'h01;  4'd2: rc = 8'h02;  4'd3: rc = 8'h04;  4'd4: rc = 8'h08;
      4'd5: rc = 8'h10;  4'd6: rc = 8'h20;  4'd7: rc = 8'h40;  4'd8: rc = 8'h80;
      4'd9: rc = 8'h1b;  4'd10: rc = 8'h36;
      default: rc = 8'h00;
    endcase
  end

  // the next round key is computed alongside each round
  assign rk_next = next_rkey(rk, rc);
  assign round_out = aes_round(st, rk_next, done_rnd);

  always_comb begin
    start_val = chain ^ q_item.data;
    if (q_item.last) start_val = start_val ^ (q_item.padded ? k2 : k1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && !ready_keys) state_next = ST_SUBKEY;
        else if (take) state_next = ST_BLOCK;
      end
      ST_SUBKEY: if (done_rnd) state_next = ST_IDLE;
      // a finished tag waits in the cipher only while the output register is busy
      ST_BLOCK: if (done_rnd) state_next = (cur_last && !can_load) ? ST_OUT : ST_IDLE;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = take;
    out_valid = out_full;
    out_tag = out_reg;
  end

  always_comb begin
    load_out = !key_wr && (((state == ST_BLOCK) && done_rnd && cur_last && can_load) ||
                           ((state == ST_OUT) && out_ready));
    load_val = (state == ST_OUT) ? chain : round_out;
  end

  assign l_val = round_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ready_keys <= 1'b0;
      chain <= '0;
      rnd <= '0;
    end else if (key_wr) begin
      state <= ST_IDLE;
      ready_keys <= 1'b0;
      chain <= '0;
      rnd <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          rnd <= 4'd1;
          rk <= key;
          if (q_valid && !ready_keys) st <= key;
          else st <= start_val ^ key;
        end
        ST_SUBKEY: begin
          rnd <= rnd + 4'd1;
          rk <= rk_next;
          st <= round_out;
          if (done_rnd) begin
            k1 <= dbl(l_val);
            k2 <= dbl(dbl(l_val));
            ready_keys <= 1'b1;
          end
        end
        ST_BLOCK: begin
          rnd <= rnd + 4'd1;
          rk <= rk_next;
          st <= round_out;
          if (done_rnd) chain <= (cur_last && can_load) ? '0 : round_out;
        end
        ST_OUT: if (out_ready) chain <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (load_out) out_full <= 1'b1;
    else if (out_ready) out_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) out_reg <= load_val;
  end

  always_ff @(posedge clk) begin
    if (take) cur_last <= q_item.last;
  end
endmodule

[rtl/aes_cmac_tag_engine_core.sv]
// aes-128 cmac tag engine
// input stream: one 16-byte block per transfer, with byte count (tuser) and tlast
// marking the final block of a message. output stream: one 128-bit tag per message,
// sent after the last block. configuration over apb: key_high at 0x00, key_low at
// 0x08, inert_pad at 0x10. write registers only while idle.
// a two-entry queue pads and classifies blocks ahead of the cipher, so input is
// taken while the cipher runs or a tag waits.
// each block passes the cipher as one load step, in which the block leaves the queue,
// and ten rounds with on-the-fly key expansion; the first block after reset or a key
// write waits for a further pass that derives the subkeys. the final round of the
// last block loads the tag into an output register, where it holds
// until taken; the cipher goes on with the next message and stalls only when a
// second tag is done while the first still waits, so a stalled receiver backs up
// the queue and then the input.
// reset clears the chain, empties the queue and the output register and marks the
// subkeys invalid; the key is zero after reset.
module aes_cmac_tag_engine_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // block_low, block_high
  input  logic [4:0]    s_tuser,   // valid_bytes
  input  logic          s_tlast,   // last_block
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // tag_low, tag_high
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import acmac_pkg::*;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         inert_pad;
  logic         wr;
  logic         key_wr;
  logic [1:0]   reg_idx;
  logic         q_valid;
  logic         q_ready;
  blk_item_t    q_item;
  logic [127:0] tag;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign key_wr = wr && (reg_idx == RegKeyHigh || reg_idx == RegKeyLow) && paddr[2:0] == 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      inert_pad <= 1'b0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        RegKeyHigh: key_high <= pwdata;
        RegKeyLow: key_low <= pwdata;
        RegInertPad: inert_pad <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyHigh: prdata = key_high;
      RegKeyLow: prdata = key_low;
      RegInertPad: prdata = {63'd0, inert_pad};
      default: prdata = '0;
    endcase
  end

  acmac_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_block({s_tdata[63:0], s_tdata[127:64]}),
    .in_count(s_tuser), .in_last(s_tlast), .inert_pad(inert_pad),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  acmac_back u_back (
    .clk(clk), .rst(rst),
    .key({key_high, key_low}), .key_wr(key_wr),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_tag(tag)
  );

  assign m_tdata = {tag[63:0], tag[127:64]};
endmodule

[rtl/acmac_checker.sv]
`include "assert_macros.svh"
module acmac_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [127:0]  m_tdata,
  input logic          pready
);
  `ASSERT_CLK(out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `ASSERT_CLK(apb_ready, clk, rst, pready)
  `ASSERT_NORST(out_reset, clk, rst |=> !m_tvalid)
endmodule

bind aes_cmac_tag_engine_core acmac_checker u_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .pready(pready)
);

[sim/cmac_tag_checker.sv]
module cmac_tag_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [4:0]   s_tuser,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           fails,
  output int           tags_pending
);
  import acmac_pkg::*;

  logic [7:0]   sub_tbl [256];
  logic [127:0] rkeys [11];
  logic [127:0] cipher_key;
  logic         zero_pad;
  logic [127:0] chain;
  logic [127:0] k1, k2;
  logic         keys_valid;
  logic [127:0] tag_queue [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      sub_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                   {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  function automatic void expand_keys();
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0]  rc;
    rc = 8'h01;
    rkeys[0] = cipher_key;
    for (int r = 1; r <= 10; r++) begin
      {w0, w1, w2, w3} = rkeys[r-1];
      t = {sub_tbl[w3[23:16]] ^ rc, sub_tbl[w3[15:8]], sub_tbl[w3[7:0]], sub_tbl[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rkeys[r] = {w0, w1, w2, w3};
      rc = gf_mul(rc, 8'h02);
    end
  endfunction

  function automatic logic [127:0] encipher(input logic [127:0] v);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    v = v ^ rkeys[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sub_tbl[v[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)%4)];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ gf_mul(a0 ^ a1, 8'h02);
          t[4*c+1] = a1 ^ x ^ gf_mul(a1 ^ a2, 8'h02);
          t[4*c+2] = a2 ^ x ^ gf_mul(a2 ^ a3, 8'h02);
          t[4*c+3] = a3 ^ x ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      v = v ^ rkeys[r];
    end
    return v;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic void absorb_block(input logic [127:0] data, input logic [4:0] count,
                                       input logic last);
    logic [127:0] blk;
    int           n;
    if (!keys_valid) begin
      expand_keys();
      k1 = gf_double(encipher(128'h0));
      k2 = gf_double(k1);
      keys_valid = 1'b1;
    end
    n = (count > 16) ? 16 : count;
    blk = data;
    for (int j = n; j < 16; j++)
      blk[127-8*j -: 8] = (j == n && !zero_pad) ? 8'h80 : 8'h00;
    chain = chain ^ blk;
    if (last) chain = chain ^ ((n < 16 && !zero_pad) ? k2 : k1);
    chain = encipher(chain);
    if (last) begin
      tag_queue.push_back(chain);
      chain = '0;
    end
  endfunction

  assign tags_pending = tag_queue.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      cipher_key <= '0;
      zero_pad   <= 1'b0;
      chain      <= '0;
      keys_valid <= 1'b0;
      fails      <= 0;
      tag_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:3] == RegKeyHigh || paddr[4:3] == RegKeyLow) begin
          if (paddr[4:3] == RegKeyHigh) cipher_key[127:64] = pwdata;
          else cipher_key[63:0] = pwdata;
          keys_valid = 1'b0;
          chain = '0;
        end else if (paddr[4:3] == RegInertPad) begin
          zero_pad = pwdata[0];
        end
      end
      // block_high travels in the low half of tdata
      if (s_tvalid && s_tready)
        absorb_block({s_tdata[63:0], s_tdata[127:64]}, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        if (tag_queue.size() == 0) begin
          $error("tag transfer with none expected: %h", m_tdata);
          fails = fails + 1;
        end else begin
          want = tag_queue.pop_front();
          if (m_tdata[63:0] !== want[127:64]) begin
            $error("tag_high: expected %h, got %h", want[127:64], m_tdata[63:0]);
            fails = fails + 1;
          end
          if (m_tdata[127:64] !== want[63:0]) begin
            $error("tag_low: expected %h, got %h", want[63:0], m_tdata[127:64]);
            fails = fails + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb.sv]
module tb;
  import acmac_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // block_low, block_high
  logic [4:0]   s_tuser;   // valid_bytes
  logic         s_tlast;   // last_block
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // tag_low, tag_high
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  int fails;
  int tags_pending;
  int send_idle;
  int recv_idle;
  int quiet_cycles;

  aes_cmac_tag_engine_core i_dut (.*);

  cmac_tag_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fails, .tags_pending
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_block(input logic [127:0] data, input logic [4:0] count,
                            input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= count;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // mostly well-formed messages: full inner blocks, any size on the last
  task automatic push_message(input int nblk);
    logic [4:0] count;
    for (int b = 0; b < nblk; b++) begin
      if (b == nblk - 1) count = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                                          : 5'($urandom_range(16));
      else count = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'd16;
      push_block(rand_block(), count, b == nblk - 1);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tags_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int sent;
    logic [63:0] kh, kl;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 19; recv_idle = 78;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: count extremes, padding on inner blocks, empty message
    push_block('0, 5'd0, 1'b1);
    push_block({128{1'b1}}, 5'd16, 1'b1);
    push_block({128{1'b1}}, 5'd1, 1'b1);
    push_block({128{1'b1}}, 5'd15, 1'b1);
    push_block(rand_block(), 5'd17, 1'b1);
    push_block(rand_block(), 5'd31, 1'b1);
    push_block(rand_block(), 5'd8, 1'b0);
    push_block(rand_block(), 5'd0, 1'b0);
    push_block('0, 5'd16, 1'b0);
    push_block({128{1'b1}}, 5'd3, 1'b1);
    push_block(rand_block(), 5'd16, 1'b0);
    push_block(rand_block(), 5'd16, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle = 19; recv_idle = 78; end
        1: begin send_idle = 78; recv_idle = 19; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: begin kh = '1; kl = '1; end
        1: begin kh = 64'h2b7e151628aed2a6; kl = 64'habf7158809cf4f3c; end
        2: begin kh = '0; kl = '0; end
        default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
      endcase
      reg_write(RegKeyHigh, kh);
      reg_write(RegKeyLow, kl);
      reg_write(RegInertPad, (ph == 5) ? 64'($urandom_range(1)) : 64'(ph % 2));
      sent = 0;
      while (sent < 300) begin
        int n;
        n = $urandom_range(6, 1);
        if ($urandom_range(19) == 0) begin
          // stray block with arbitrary count and last mark
          push_block(rand_block(), 5'($urandom_range(31)), 1'($urandom_range(1)));
          n = 1;
        end else push_message(n);
        sent += n;
      end
      drain();
    end

    if (fails == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
